@@ hw/rtl/sbf_pkg.sv @@
`timescale 1ns / 1ps

package sbf_pkg;

  // ip is kept wide enough that a forward jump never wraps
  localparam int IP_W         = 33;
  localparam int RECORD_WORDS = 16;

  localparam logic [1:0] FUNC_PROG = 2'd0;
  localparam logic [1:0] FUNC_REC  = 2'd1;
  localparam logic [1:0] FUNC_RUN  = 2'd2;

  localparam logic [0:0] CFG_PROGRAM_LENGTH = 1'b0;
  localparam logic [0:0] CFG_HOST_LE        = 1'b1;

  localparam logic [15:0] OP_LD_W_ABS = 16'h0020;
  localparam logic [15:0] OP_OR_K     = 16'h0044;
  localparam logic [15:0] OP_AND_K    = 16'h0054;
  localparam logic [15:0] OP_JA       = 16'h0005;
  localparam logic [15:0] OP_JEQ_K    = 16'h0015;
  localparam logic [15:0] OP_JGT_K    = 16'h0025;
  localparam logic [15:0] OP_JGE_K    = 16'h0035;
  localparam logic [15:0] OP_RET_K    = 16'h0006;

  localparam logic [31:0] ACT_MASK  = 32'h7fff_0000;
  localparam logic [31:0] ACT_KILL  = 32'h0000_0000;
  localparam logic [31:0] ACT_TRAP  = 32'h0003_0000;
  localparam logic [31:0] ACT_ERRNO = 32'h0005_0000;
  localparam logic [31:0] ACT_TRACE = 32'h7ff0_0000;
  localparam logic [31:0] ACT_ALLOW = 32'h7fff_0000;

  // last byte offset at which a whole word still fits in the record
  localparam logic [31:0] LOAD_LIMIT = 32'd60;

  localparam logic [2:0] KIND_KILL  = 3'd0;
  localparam logic [2:0] KIND_TRAP  = 3'd1;
  localparam logic [2:0] KIND_ERRNO = 3'd2;
  localparam logic [2:0] KIND_TRACE = 3'd3;
  localparam logic [2:0] KIND_ALLOW = 3'd4;

  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_BAD_ACTION  = 3'd1;
  localparam logic [2:0] STAT_LOAD_RANGE  = 3'd2;
  localparam logic [2:0] STAT_FELL_OFF    = 3'd3;
  localparam logic [2:0] STAT_UNSUPPORTED = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic run_init;
    logic fetch;
    logic exec;
    logic load;
    logic end_run;
  } dp_cmd_t;

  typedef struct packed {
    logic at_end;
    logic exec_stop;
    logic exec_load;
  } dp_status_t;

endpackage

@@ hw/rtl/sbf_ctrl.sv @@
`timescale 1ns / 1ps

module sbf_ctrl
  import sbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] func,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;
  logic   done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start && func == FUNC_RUN) begin
          cmd.run_init = 1'b1;
          state_next   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (status.at_end) begin
          cmd.end_run = 1'b1;
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        priority if (status.exec_stop) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (status.exec_load) begin
          state_next = ST_LOAD;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_FETCH;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

@@ hw/rtl/sbf_datapath.sv @@
`timescale 1ns / 1ps

module sbf_datapath
  import sbf_pkg::*;
#(
  parameter int PROGRAM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  func,
  input  logic [11:0] slot_index,
  input  logic [15:0] opcode_word,
  input  logic [7:0]  jump_true,
  input  logic [7:0]  jump_false,
  input  logic [31:0] operand_k,
  input  logic [31:0] record_word,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic [2:0]  action_kind,
  output logic [15:0] action_data,
  output logic [2:0]  run_status,
  output logic [11:0] stop_slot
);

  localparam int AW = $clog2(PROGRAM_DEPTH);
  localparam logic [16:0] DEPTH_V = 17'(PROGRAM_DEPTH);

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  logic [63:0] prog_mem [PROGRAM_DEPTH];
  logic [63:0] prog_rdata;
  logic [31:0] rec_mem [RECORD_WORDS];
  logic [31:0] rec_lo, rec_hi;
  logic [1:0]  lane;

  logic [12:0]     program_length;
  logic            host_le;
  logic            arch_le;
  logic            swap;
  logic [31:0]     acc, acc_next;
  logic [IP_W-1:0] ip, ip_next;
  logic [11:0]     last;

  logic [15:0] code;
  logic [7:0]  jt, jf;
  logic [31:0] k, act;
  logic        exec_stop, exec_load;
  logic [2:0]  stop_kind, stop_status;
  logic [15:0] stop_data;

  logic [63:0] pair_le, pair_be, shift_be;
  logic [31:0] v_le, v_be, v_host, load_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
      host_le        <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PROGRAM_LENGTH: program_length <= cfg_data;
        CFG_HOST_LE:        host_le        <= cfg_data[0];
      endcase
    end
  end

  // program memory: write on a load transfer, registered read on fetch
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_PROG && {5'b0, slot_index} < DEPTH_V)
      prog_mem[AW'(slot_index)] <= {opcode_word, jump_true, jump_false, operand_k};
    if (cmd.fetch)
      prog_rdata <= prog_mem[ip[AW-1:0]];
  end

  // record memory: two registered read ports for a word that may straddle
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_REC && slot_index < 12'(RECORD_WORDS)) begin
      rec_mem[slot_index[3:0]] <= record_word;
      if (slot_index == 12'd1)
        arch_le <= record_word[30];
    end
    if (cmd.exec && exec_load) begin
      rec_lo <= rec_mem[k[5:2]];
      rec_hi <= rec_mem[k[5:2] + 4'd1];
      lane   <= k[1:0];
    end
  end

  assign code = swap ? swap16(prog_rdata[63:48]) : prog_rdata[63:48];
  assign jt   = prog_rdata[47:40];
  assign jf   = prog_rdata[39:32];
  assign k    = swap ? swap32(prog_rdata[31:0]) : prog_rdata[31:0];
  assign act  = k & ACT_MASK;

  always_comb begin
    acc_next    = acc;
    ip_next     = ip;
    exec_stop   = 1'b0;
    exec_load   = 1'b0;
    stop_kind   = KIND_KILL;
    stop_data   = '0;
    stop_status = STAT_OK;
    unique case (code)
      OP_LD_W_ABS: begin
        if (k <= LOAD_LIMIT) begin
          exec_load = 1'b1;
        end else begin
          exec_stop   = 1'b1;
          stop_status = STAT_LOAD_RANGE;
        end
      end
      OP_OR_K:  acc_next = acc | k;
      OP_AND_K: acc_next = acc & k;
      OP_JA:    ip_next  = ip + IP_W'(k);
      OP_JEQ_K: ip_next  = ip + IP_W'((acc == k) ? jt : jf);
      OP_JGT_K: ip_next  = ip + IP_W'((acc > k) ? jt : jf);
      OP_JGE_K: ip_next  = ip + IP_W'((acc >= k) ? jt : jf);
      OP_RET_K: begin
        exec_stop = 1'b1;
        stop_data = k[15:0];
        priority if (act == ACT_KILL) begin
          stop_kind = KIND_KILL;
        end else if (act == ACT_TRAP) begin
          stop_kind = KIND_TRAP;
        end else if (act == ACT_ERRNO) begin
          stop_kind = KIND_ERRNO;
        end else if (act == ACT_TRACE) begin
          stop_kind = KIND_TRACE;
        end else if (act == ACT_ALLOW) begin
          stop_kind = KIND_ALLOW;
        end else begin
          stop_status = STAT_BAD_ACTION;
          stop_data   = '0;
        end
      end
      default: begin
        exec_stop   = 1'b1;
        stop_status = STAT_UNSUPPORTED;
      end
    endcase
  end

  // unaligned word: little endian takes bytes upward, big endian downward
  always_comb begin
    pair_le  = {rec_hi, rec_lo};
    pair_be  = {rec_lo, rec_hi};
    v_le     = 32'(pair_le >> {lane, 3'b000});
    shift_be = pair_be << {lane, 3'b000};
    v_be     = shift_be[63:32];
    v_host   = host_le ? v_le : v_be;
    load_val = swap ? swap32(v_host) : v_host;
  end

  assign status.at_end    = (ip >= IP_W'(program_length)) || (ip >= IP_W'(PROGRAM_DEPTH));
  assign status.exec_stop = exec_stop;
  assign status.exec_load = exec_load;

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      acc  <= '0;
      ip   <= '0;
      last <= '0;
      swap <= (arch_le != host_le);
    end
    if (cmd.fetch) begin
      last <= ip[11:0];
      ip   <= ip + IP_W'(1);
    end
    if (cmd.exec) begin
      acc <= acc_next;
      ip  <= ip_next;
    end
    if (cmd.load)
      acc <= load_val;
    if (cmd.exec && exec_stop) begin
      action_kind <= stop_kind;
      action_data <= stop_data;
      run_status  <= stop_status;
      stop_slot   <= last;
    end
    if (cmd.end_run) begin
      action_kind <= KIND_KILL;
      action_data <= '0;
      run_status  <= STAT_FELL_OFF;
      stop_slot   <= last;
    end
  end

endmodule

@@ hw/rtl/seccomp_bpf_filter_engine.sv @@
`timescale 1ns / 1ps

// Classic BPF filter engine over a 64-byte syscall record.
// Command channel: a transfer happens at a clock edge with start high and
// busy low. func 0 writes one program slot, func 1 writes one record word;
// both give no result. func 2 runs the program from slot 0 and gives
// exactly one result. In a run each executed instruction goes through a
// program memory fetch and an execute step, a word load also through a
// registered read of the record memory; a run that falls off the end of
// the program ends in the fetch state. The result strobe done is high for
// one cycle right after the last step, with action_kind, action_data,
// run_status and stop_slot valid alongside. busy is high for the whole
// run and drops in the cycle that shows done, so a new command may be
// given in that cycle. The receiver cannot stall: each result stands for
// one cycle only. Configuration (program_length, host_little_endian) is
// written through cfg_write/cfg_index/cfg_data; the user must do so only while
// the engine is idle, and the engine itself does not enforce this.
// Synchronous reset returns the engine to idle with program_length 0 and
// host_little_endian 1; program and record memories are not cleared.
module seccomp_bpf_filter_engine
  import sbf_pkg::*;
#(
  parameter int PROGRAM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [11:0] slot_index,
  input  logic [15:0] opcode_word,
  input  logic [7:0]  jump_true,
  input  logic [7:0]  jump_false,
  input  logic [31:0] operand_k,
  input  logic [31:0] record_word,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        done,
  output logic [2:0]  action_kind,
  output logic [15:0] action_data,
  output logic [2:0]  run_status,
  output logic [11:0] stop_slot
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       accept;

  assign accept = start && !busy;

  sbf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  sbf_datapath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func),
    .slot_index  (slot_index),
    .opcode_word (opcode_word),
    .jump_true   (jump_true),
    .jump_false  (jump_false),
    .operand_k   (operand_k),
    .record_word (record_word),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .action_kind (action_kind),
    .action_data (action_data),
    .run_status  (run_status),
    .stop_slot   (stop_slot)
  );

endmodule

@@ hw/rtl/sbf_checker.sv @@
`timescale 1ns / 1ps

module sbf_checker
  import sbf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func,
  input logic        done,
  input logic [2:0]  action_kind,
  input logic [15:0] action_data,
  input logic [2:0]  run_status
);

  // a run transfer always makes the engine busy
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_RUN) |=> busy)
    else $error("run transfer did not raise busy");

  // the result shows exactly as the run ends
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe not at end of run");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // an error result carries no action
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && run_status != STAT_OK) |-> (action_kind == KIND_KILL && action_data == 16'd0))
    else $error("error result with action fields set");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    (done && run_status == STAT_OK) |-> (action_kind <= KIND_ALLOW))
    else $error("action kind out of range");

endmodule

bind seccomp_bpf_filter_engine sbf_checker u_sbf_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .func        (func),
  .done        (done),
  .action_kind (action_kind),
  .action_data (action_data),
  .run_status  (run_status)
);

@@ dv/tb_seccomp_bpf_filter_engine.sv @@
`timescale 1ns / 1ps

module tb_seccomp_bpf_filter_engine;
  import sbf_pkg::*;

  localparam int PROGRAM_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [31:0] NR_WATCHED = 32'd59;
  localparam logic [31:0] ARCH_X86_64 = 32'hc000_003e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] data;
    logic [2:0]  status;
    logic [11:0] slot;
  } filter_verdict_t;

  typedef struct {
    logic [1:0]  fn;
    logic [11:0] slot;
    logic [15:0] code;
    logic [7:0]  jt;
    logic [7:0]  jf;
    logic [31:0] k;
    logic [31:0] word;
  } command_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = FUNC_NONE;
  logic [11:0] slot_index = '0;
  logic [15:0] opcode_word = '0;
  logic [7:0]  jump_true = '0;
  logic [7:0]  jump_false = '0;
  logic [31:0] operand_k = '0;
  logic [31:0] record_word = '0;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = CFG_PROGRAM_LENGTH;
  logic [12:0] cfg_data = '0;
  logic        done;
  logic [2:0]  action_kind;
  logic [15:0] action_data;
  logic [2:0]  run_status;
  logic [11:0] stop_slot;

  // shadow of the engine state
  logic [63:0] filter_prog [PROGRAM_DEPTH];
  bit          prog_loaded [PROGRAM_DEPTH];
  logic [31:0] sys_record [RECORD_WORDS];
  logic [12:0] prog_len = '0;
  logic        host_le = 1'b1;

  filter_verdict_t pending_verdicts [$];
  int errors = 0;
  int useful_count = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  seccomp_bpf_filter_engine dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .slot_index(slot_index),
    .opcode_word(opcode_word),
    .jump_true(jump_true),
    .jump_false(jump_false),
    .operand_k(operand_k),
    .record_word(record_word),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .action_kind(action_kind),
    .action_data(action_data),
    .run_status(run_status),
    .stop_slot(stop_slot)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL seccomp_bpf_filter_engine");
      $finish;
    end
  end

  function automatic logic [15:0] byte_swap16(logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] byte_swap32(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic target_swapped();
    return sys_record[1][30] != host_le;
  endfunction

  // record bytes in host memory order
  function automatic logic [7:0] record_byte(logic [5:0] b);
    logic [1:0] lane;
    lane = host_le ? b[1:0] : 2'd3 - b[1:0];
    return sys_record[b[5:2]][8*lane +: 8];
  endfunction

  function automatic void predict_verdict(output filter_verdict_t v, output int missing);
    logic [63:0] ip;
    logic [63:0] len;
    logic [31:0] acc;
    logic [31:0] k;
    logic [31:0] word;
    logic [15:0] code;
    logic [7:0]  jt;
    logic [7:0]  jf;
    logic [7:0]  bytes [4];
    logic [11:0] last;
    logic        swap;
    v = '{kind: KIND_KILL, data: 16'h0, status: STAT_FELL_OFF, slot: 12'h0};
    missing = -1;
    ip = '0;
    last = '0;
    acc = '0;
    len = (prog_len > 13'(PROGRAM_DEPTH)) ? 64'(PROGRAM_DEPTH) : 64'(prog_len);
    swap = target_swapped();
    while (ip < len) begin
      if (!prog_loaded[ip[11:0]]) begin
        missing = int'(ip[11:0]);
        return;
      end
      {code, jt, jf, k} = filter_prog[ip[11:0]];
      last = ip[11:0];
      ip++;
      if (swap) begin
        code = byte_swap16(code);
        k = byte_swap32(k);
      end
      case (code)
        OP_LD_W_ABS: begin
          if (k > LOAD_LIMIT) begin
            v.status = STAT_LOAD_RANGE;
            v.slot = last;
            return;
          end
          for (int i = 0; i < 4; i++) bytes[i] = record_byte(k[5:0] + 6'(i));
          word = host_le ? {bytes[3], bytes[2], bytes[1], bytes[0]}
                         : {bytes[0], bytes[1], bytes[2], bytes[3]};
          acc = swap ? byte_swap32(word) : word;
        end
        OP_OR_K:  acc = acc | k;
        OP_AND_K: acc = acc & k;
        OP_JA:    ip = ip + 64'(k);
        OP_JEQ_K: ip = ip + 64'((acc == k) ? jt : jf);
        OP_JGT_K: ip = ip + 64'((acc > k) ? jt : jf);
        OP_JGE_K: ip = ip + 64'((acc >= k) ? jt : jf);
        OP_RET_K: begin
          v.slot = last;
          case (k & ACT_MASK)
            ACT_KILL:  v.kind = KIND_KILL;
            ACT_TRAP:  v.kind = KIND_TRAP;
            ACT_ERRNO: v.kind = KIND_ERRNO;
            ACT_TRACE: v.kind = KIND_TRACE;
            ACT_ALLOW: v.kind = KIND_ALLOW;
            default: begin
              v.status = STAT_BAD_ACTION;
              return;
            end
          endcase
          v.status = STAT_OK;
          v.data = k[15:0];
          return;
        end
        default: begin
          v.status = STAT_UNSUPPORTED;
          v.slot = last;
          return;
        end
      endcase
    end
    v.slot = last;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    filter_verdict_t want;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result kind %0d data %0h status %0d slot %0d",
                 $time, action_kind, action_data, run_status, stop_slot);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("action_kind", 32'(want.kind), 32'(action_kind));
        check_field("action_data", 32'(want.data), 32'(action_data));
        check_field("run_status", 32'(want.status), 32'(run_status));
        check_field("stop_slot", 32'(want.slot), 32'(stop_slot));
      end
    end
  end

  // instruction in target byte order for the current record and host setting
  function automatic logic [63:0] encode_insn(logic [15:0] code, logic [7:0] jt,
                                              logic [7:0] jf, logic [31:0] k);
    if (target_swapped()) return {byte_swap16(code), jt, jf, byte_swap32(k)};
    return {code, jt, jf, k};
  endfunction

  function automatic logic [31:0] random_word();
    if ($urandom_range(0, 3) == 0) return 32'($urandom_range(0, 300));
    return 32'($urandom);
  endfunction

  function automatic logic [63:0] random_insn(bit closing);
    int pick;
    logic [15:0] code;
    logic [7:0]  jt;
    logic [7:0]  jf;
    logic [31:0] k;
    logic [31:0] act;
    pick = closing ? 90 : $urandom_range(0, 99);
    jt = 8'($urandom);
    jf = 8'($urandom);
    k = $urandom;
    if (pick < 25) begin
      code = OP_LD_W_ABS;
      case ($urandom_range(0, 9))
        0: k = $urandom_range(0, 63);
        1: k = 32'hffff_fffc + 32'($urandom_range(0, 3)); // wraps if k+4 is 32 bits
        2: ;
        default: k = 4 * $urandom_range(0, 15);
      endcase
    end else if (pick < 35) begin
      code = (pick < 30) ? OP_OR_K : OP_AND_K;
    end else if (pick < 40) begin
      code = OP_JA;
      if ($urandom_range(0, 7) != 0) k = $urandom_range(0, 3);
    end else if (pick < 70) begin
      case ($urandom_range(0, 2))
        0: code = OP_JEQ_K;
        1: code = OP_JGT_K;
        default: code = OP_JGE_K;
      endcase
      if ($urandom_range(0, 7) != 0) begin
        jt = 8'($urandom_range(0, 3));
        jf = 8'($urandom_range(0, 3));
      end
      // compare against what a word load would put in the accumulator
      if ($urandom_range(0, 1) == 0) begin
        k = sys_record[4'($urandom_range(0, 15))] + 32'($urandom_range(0, 2)) - 32'd1;
        if (target_swapped()) k = byte_swap32(k);
      end else begin
        k = random_word();
      end
    end else if (pick < 95) begin
      code = OP_RET_K;
      case ($urandom_range(0, 5))
        0: act = ACT_KILL;
        1: act = ACT_TRAP;
        2: act = ACT_ERRNO;
        3: act = ACT_TRACE;
        4: act = ACT_ALLOW;
        default: act = 32'($urandom) & ACT_MASK;
      endcase
      k = (k & ~ACT_MASK) | act;
    end else begin
      code = 16'($urandom);
    end
    return encode_insn(code, jt, jf, k);
  endfunction

  function automatic command_t random_cmd(logic [1:0] fn);
    command_t c;
    c.fn = fn;
    c.slot = 12'($urandom);
    c.code = 16'($urandom);
    c.jt = 8'($urandom);
    c.jf = 8'($urandom);
    c.k = $urandom;
    c.word = $urandom;
    return c;
  endfunction

  task automatic send_item(input command_t c);
    int gap;
    int missing;
    filter_verdict_t v;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= c.fn;
    slot_index <= c.slot;
    opcode_word <= c.code;
    jump_true <= c.jt;
    jump_false <= c.jf;
    operand_k <= c.k;
    record_word <= c.word;
    do @(posedge clk); while (busy);
    // transfer done: update the shadow state in command order
    case (c.fn)
      FUNC_PROG: begin
        filter_prog[c.slot] = {c.code, c.jt, c.jf, c.k};
        prog_loaded[c.slot] = 1'b1;
        useful_count++;
      end
      FUNC_REC: begin
        if (c.slot < RECORD_WORDS) begin
          sys_record[c.slot[3:0]] = c.word;
          useful_count++;
        end
      end
      FUNC_RUN: begin
        predict_verdict(v, missing);
        pending_verdicts.push_back(v);
        useful_count++;
      end
      default: ;
    endcase
  endtask

  task automatic write_slot(input logic [11:0] slot, input logic [63:0] insn);
    command_t c;
    c = random_cmd(FUNC_PROG);
    c.slot = slot;
    {c.code, c.jt, c.jf, c.k} = insn;
    send_item(c);
  endtask

  task automatic write_word(input logic [11:0] idx, input logic [31:0] word);
    command_t c;
    c = random_cmd(FUNC_REC);
    c.slot = idx;
    c.word = word;
    send_item(c);
  endtask

  // never lets a run fetch a slot that was not written
  task automatic run_filter();
    filter_verdict_t v;
    int missing;
    predict_verdict(v, missing);
    while (missing >= 0) begin
      write_slot(12'(missing), random_insn(1'b0));
      predict_verdict(v, missing);
    end
    send_item(random_cmd(FUNC_RUN));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [12:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_PROGRAM_LENGTH) prog_len = val;
    else host_le = val[0];
    @(posedge clk);
  endtask

  task automatic load_program(input logic [63:0] insns [$], input logic [12:0] len);
    wait_idle();
    write_reg(CFG_PROGRAM_LENGTH, len);
    foreach (insns[i]) write_slot(12'(i), insns[i]);
  endtask

  task automatic test_record_setup();
    for (int i = 0; i < RECORD_WORDS; i++)
      write_word(12'(i), (i == 0) ? NR_WATCHED : (i == 1) ? ARCH_X86_64 : random_word());
  endtask

  task automatic test_empty_program();
    run_filter();
  endtask

  task automatic test_basic_filter();
    load_program('{encode_insn(OP_LD_W_ABS, 8'd0, 8'd0, 32'd0),
                   encode_insn(OP_JEQ_K, 8'd0, 8'd1, NR_WATCHED),
                   encode_insn(OP_RET_K, 8'd0, 8'd0, ACT_ALLOW | 32'h0000_beef),
                   encode_insn(OP_RET_K, 8'd0, 8'd0, ACT_ERRNO | 32'h0000_0001)}, 13'd4);
    run_filter();
    write_word(12'd0, NR_WATCHED + 32'd1);
    run_filter();
  endtask

  task automatic test_each_operation();
    // unaligned load straddles words 0 and 1, then or/and/jgt/jge with an exact match
    load_program('{encode_insn(OP_LD_W_ABS, 8'd0, 8'd0, 32'd1),
                   encode_insn(OP_OR_K, 8'd0, 8'd0, 32'h8000_0001),
                   encode_insn(OP_AND_K, 8'd0, 8'd0, 32'hffff_00ff),
                   encode_insn(OP_JGT_K, 8'd1, 8'd0, 32'd0),
                   encode_insn(OP_RET_K, 8'd0, 8'd0, ACT_KILL),
                   encode_insn(OP_JGE_K, 8'd0, 8'd255, 32'hbe00_0001),
                   encode_insn(OP_RET_K, 8'd0, 8'd0, ACT_TRAP | 32'h8000_0042)}, 13'd7);
    run_filter();
  endtask

  task automatic test_error_stops();
    load_program('{encode_insn(OP_LD_W_ABS, 8'd0, 8'd0, 32'hffff_fffc)}, 13'd1);
    run_filter();
    // last word that fits, then one byte past it
    load_program('{encode_insn(OP_LD_W_ABS, 8'd0, 8'd0, 32'd60),
                   encode_insn(OP_LD_W_ABS, 8'd0, 8'd0, 32'd61)}, 13'd2);
    run_filter();
    load_program('{encode_insn(OP_RET_K, 8'd0, 8'd0, 32'h0001_0000)}, 13'd1);
    run_filter();
    load_program('{encode_insn(16'h0007, 8'd0, 8'd0, 32'd0)}, 13'd1);
    run_filter();
    load_program('{encode_insn(OP_JA, 8'd0, 8'd0, 32'hffff_ffff)}, 13'd1);
    run_filter();
  endtask

  task automatic test_byte_swapped();
    wait_idle();
    write_reg(CFG_HOST_LE, 13'd0);
    write_word(12'd0, NR_WATCHED);
    load_program('{encode_insn(OP_LD_W_ABS, 8'd0, 8'd0, 32'd0),
                   encode_insn(OP_JEQ_K, 8'd0, 8'd1, byte_swap32(NR_WATCHED)),
                   encode_insn(OP_RET_K, 8'd0, 8'd0, ACT_TRACE | 32'h0000_0007),
                   encode_insn(OP_RET_K, 8'd0, 8'd0, ACT_KILL)}, 13'd4);
    run_filter();
    wait_idle();
    write_reg(CFG_HOST_LE, 13'd1);
  endtask

  task automatic test_top_slot();
    load_program('{encode_insn(OP_JA, 8'd0, 8'd0, 32'd4094)}, 13'h1fff);
    write_slot(12'hfff, encode_insn(OP_RET_K, 8'hff, 8'hff, ACT_ALLOW | 32'h0000_ffff));
    run_filter();
    wait_idle();
    write_reg(CFG_PROGRAM_LENGTH, 13'd4096);
    run_filter();
  endtask

  task automatic disturb(input int n);
    logic [31:0] w;
    logic [11:0] idx;
    case ($urandom_range(0, 5))
      0, 1: begin
        idx = 12'($urandom_range(0, RECORD_WORDS - 1));
        w = random_word();
        // mostly keep the arch byte order so programs stay decodable
        if (idx == 12'd1 && $urandom_range(0, 7) != 0) w[30] = sys_record[1][30];
        write_word(idx, w);
      end
      2: write_slot(12'($urandom_range(0, n - 1)), random_insn(1'b0));
      3: send_item(random_cmd(FUNC_NONE));
      4: write_word(12'($urandom_range(RECORD_WORDS, 4095)), $urandom);
      default: write_slot(12'($urandom), random_insn(1'b0));
    endcase
  endtask

  task automatic test_random_filters();
    int goal;
    int n;
    logic [12:0] len;
    logic [31:0] w;
    goal = useful_count + 900;
    while (useful_count < goal) begin
      wait_idle();
      write_reg(CFG_HOST_LE, {12'($urandom), 1'($urandom)});
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 20);
      case ($urandom_range(0, 19))
        0: len = 13'd0;
        1: len = 13'd4096;
        2: len = 13'h1fff;
        3: len = 13'($urandom);
        4, 5: len = 13'($urandom_range(0, n));
        6, 7: len = 13'(n + $urandom_range(1, 40));
        default: len = 13'(n);
      endcase
      write_reg(CFG_PROGRAM_LENGTH, len);
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < RECORD_WORDS; i++) begin
          w = random_word();
          if (i == 1) w[30] = 1'($urandom);
          write_word(12'(i), w);
        end
      end
      for (int i = 0; i < n; i++)
        write_slot(12'(i), random_insn(i == n - 1 && $urandom_range(0, 4) != 0));
      repeat ($urandom_range(2, 6)) begin
        repeat ($urandom_range(0, 2)) disturb(n);
        run_filter();
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_record_setup();
    test_empty_program();
    test_basic_filter();
    test_each_operation();
    test_error_stops();
    test_byte_swapped();
    test_top_slot();
    test_random_filters();
    wait_idle();
    repeat (16) @(posedge clk);
    if (errors == 0) $display("PASS seccomp_bpf_filter_engine");
    else $display("FAIL seccomp_bpf_filter_engine");
    $finish;
  end

endmodule
